>>> design/ocme_pkg.sv
// shared types and constants for the octree child mask expander
// no dependencies; imported by ocme_ctrl, ocme_dpath and the top level
package ocme_pkg;

  localparam int COORD_W     = 24;
  localparam int LEVEL_OUT_W = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_DEPTH = 2'd0;
  localparam logic [1:0] REG_ROOT_X    = 2'd1;
  localparam logic [1:0] REG_ROOT_Y    = 2'd2;
  localparam logic [1:0] REG_ROOT_Z    = 2'd3;

  // configuration reset values
  localparam logic [2:0]         MAX_DEPTH_RST = 3'd6;
  localparam logic [COORD_W-1:0] ROOT_X_RST    = 24'd640;
  localparam logic [COORD_W-1:0] ROOT_Y_RST    = 24'd0;
  localparam logic [COORD_W-1:0] ROOT_Z_RST    = 24'd0;

  typedef logic signed [COORD_W-1:0] coord_t;

  // request operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_EXPAND = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_RUN        = 2'd0,
    ST_DONE       = 2'd1,
    ST_UNWRITTEN  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // controller to datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_WRITE,
    CMD_START,
    CMD_EMPTY,
    CMD_POP,
    CMD_LOAD,
    CMD_LATCH,
    CMD_CHILD,
    CMD_FAIL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t code;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic out_free;
    logic stack_empty;
    logic level_bad;
    logic node_unwritten;
    logic last_child;
  } dp_sts_t;

  // one result item
  typedef struct packed {
    logic                   box_valid;
    coord_t                 box_x;
    coord_t                 box_y;
    coord_t                 box_z;
    logic [LEVEL_OUT_W-1:0] box_level;
    logic                   last;
    status_t                status;
  } result_t;

endpackage

>>> design/octree_child_mask_expander_top.sv
// top level of the octree child mask expander: port packing only
// depends on ocme_pkg, ocme_ctrl and ocme_dpath
//
//  channel | direction | contents
//  in_     | sink      | tuser: operation; tdata: node_address, node_word
//  out_    | source    | tuser: box_valid, status; tdata: box corner and level; tlast
//  cfg_    | sink      | write enable, register index, write data
//
// a write, a start and an expand of an empty stack are handled in the accepting state
// an expand: one stack memory read, one node memory read, then one child box per cycle
// through the output register while it is free; one boxless result if no child is valid
// after reset a clearing pass over all NODE_WORDS words resets the written flags in the
// node memory; no request is taken until it ends, configuration writes are taken
// a stalled output holds the child sequence; the next request waits for a free slot

module octree_child_mask_expander_top
  import ocme_pkg::*;
#(
  parameter int NODE_WORDS    = 4096,
  parameter int STACK_ENTRIES = 64,
  parameter int LEVELS        = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_W-1:0]     cfg_wdata,
  // requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // node_address[11:0], node_word[43:12]
  input  logic [1:0]             in_tuser,   // operation[1:0]
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // box_x[23:0], box_y[47:24], box_z[71:48],
                                             // box_level[75:72]
  output logic [2:0]             out_tuser,  // box_valid[0], status[2:1]
  output logic                   out_tlast
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  result_t  res;

  ocme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ocme_dpath #(
    .NODE_WORDS    (NODE_WORDS),
    .STACK_ENTRIES (STACK_ENTRIES),
    .LEVELS        (LEVELS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_node_address (in_tdata[11:0]),
    .in_node_word    (in_tdata[43:12]),
    .cmd             (cmd),
    .sts             (sts),
    .out_tready      (out_tready),
    .out_vld         (out_tvalid),
    .out_res         (res)
  );

  // result packing
  assign out_tdata = {4'd0, res.box_level, res.box_z, res.box_y, res.box_x};
  assign out_tuser = {res.status, res.box_valid};
  assign out_tlast = res.last;

endmodule

>>> design/ocme_ctrl.sv
// controller state machine for the octree child mask expander
// depends on ocme_pkg; drives commands into ocme_dpath

module ocme_ctrl
  import ocme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic [1:0] in_op,
  output logic     in_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_READ,
    S_CHILD,
    S_FAIL
  } state_t;

  state_t  state_r, state_nxt;
  status_t fail_r, fail_nxt;
  logic    accept;

  assign in_tready = (state_r == S_IDLE) && sts.clear_done && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    fail_nxt  = fail_r;
    cmd.op    = CMD_IDLE;
    cmd.code  = fail_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_WRITE: cmd.op = CMD_WRITE;
            OP_START: cmd.op = CMD_START;
            OP_EXPAND: begin
              if (sts.stack_empty) begin
                cmd.op = CMD_EMPTY;
              end else begin
                cmd.op    = CMD_POP;
                state_nxt = S_POP;
              end
            end
            default: cmd.op = CMD_IDLE;
          endcase
        end
      end
      // popped entry is in the stack read register
      S_POP: begin
        if (sts.level_bad) begin
          fail_nxt  = ST_DONE;
          state_nxt = S_FAIL;
        end else begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_READ;
        end
      end
      // node word is in the memory read register
      S_READ: begin
        if (sts.node_unwritten) begin
          fail_nxt  = ST_UNWRITTEN;
          state_nxt = S_FAIL;
        end else begin
          cmd.op    = CMD_LATCH;
          state_nxt = S_CHILD;
        end
      end
      // one child result per free output slot
      S_CHILD: begin
        if (sts.out_free) begin
          cmd.op = CMD_CHILD;
          if (sts.last_child) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.op    = CMD_FAIL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and failure code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fail_r  <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

>>> design/ocme_dpath.sv
// datapath: node memory, traversal stack, child box generation and output register
// depends on ocme_pkg; commanded by ocme_ctrl

module ocme_dpath
  import ocme_pkg::*;
#(
  parameter int NODE_WORDS    = 4096,
  parameter int STACK_ENTRIES = 64,
  parameter int LEVELS        = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [COORD_W-1:0]  cfg_wdata,
  input  logic [11:0]         in_node_address,
  input  logic [31:0]         in_node_word,
  input  ctl_cmd_t            cmd,
  output dp_sts_t             sts,
  input  logic                out_tready,
  output logic                out_vld,
  output result_t             out_res
);

  localparam int AW = $clog2(NODE_WORDS);
  localparam int SW = $clog2(STACK_ENTRIES);
  localparam int CW = $clog2(STACK_ENTRIES + 1);
  localparam int LW = $clog2(LEVELS + 1);

  typedef struct packed {
    logic [AW-1:0] addr;
    coord_t        x;
    coord_t        y;
    coord_t        z;
    logic [LW-1:0] lvl;
  } stk_ent_t;

  // configuration registers
  logic [2:0] max_depth_r;
  coord_t     root_x_r, root_y_r, root_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= MAX_DEPTH_RST;
      root_x_r    <= ROOT_X_RST;
      root_y_r    <= ROOT_Y_RST;
      root_z_r    <= ROOT_Z_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MAX_DEPTH: max_depth_r <= cfg_wdata[2:0];
        REG_ROOT_X:    root_x_r    <= cfg_wdata;
        REG_ROOT_Y:    root_y_r    <= cfg_wdata;
        REG_ROOT_Z:    root_z_r    <= cfg_wdata;
        default:       max_depth_r <= max_depth_r;
      endcase
    end
  end

  // written-flag clearing sweep after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(NODE_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // node memory, bit 32 is the written flag
  logic [32:0]   node_mem [NODE_WORDS];
  logic [32:0]   node_q;
  logic          node_we, node_re;
  logic [AW-1:0] node_widx, node_ridx;
  logic [32:0]   node_wdata;
  logic          addr_ok;
  stk_ent_t      stk_q;

  assign addr_ok = 32'(in_node_address) < 32'(NODE_WORDS);

  always_comb begin
    node_we    = 1'b0;
    node_widx  = AW'({16'd0, in_node_address});
    node_wdata = {1'b1, in_node_word};
    if (clr_busy_r) begin
      node_we    = 1'b1;
      node_widx  = clr_idx_r;
      node_wdata = '0;
    end else if (cmd.op == CMD_WRITE && addr_ok) begin
      node_we = 1'b1;
    end
  end

  assign node_re   = (cmd.op == CMD_LOAD);
  assign node_ridx = stk_q.addr;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_widx] <= node_wdata;
    end
    if (node_re) begin
      node_q <= node_mem[node_ridx];
    end
  end

  // traversal stack memory and fill count
  stk_ent_t      stk_mem [STACK_ENTRIES];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          stk_we, stk_re;
  logic [SW-1:0] stk_widx, stk_ridx;
  stk_ent_t      stk_wdata;
  logic [CW-1:0] cnt_dec;

  assign cnt_dec  = cnt_r - CW'(1);
  assign stk_re   = (cmd.op == CMD_POP);
  assign stk_ridx = cnt_dec[SW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_widx] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ridx];
    end
  end

  // parent entry and node masks of the expansion in progress
  logic [AW-1:0] par_addr_r;
  coord_t        par_x_r, par_y_r, par_z_r;
  logic [LW-1:0] par_lvl_r;
  logic [7:0]    rem_r, leaf_r;
  logic [AW-1:0] first_r;
  logic [2:0]    rank_r;
  logic [7:0]    half_r;
  logic          ovf_r;
  logic [7:0]    valid_rev, leaf_rev;

  // mask bit 7-k belongs to octant k
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      valid_rev[k] = node_q[15 - k];
      leaf_rev[k]  = node_q[7 - k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      par_addr_r <= stk_q.addr;
      par_x_r    <= stk_q.x;
      par_y_r    <= stk_q.y;
      par_z_r    <= stk_q.z;
      par_lvl_r  <= stk_q.lvl;
    end
    if (cmd.op == CMD_LATCH) begin
      first_r <= AW'(node_q[31:16]) + par_addr_r;
      leaf_r  <= leaf_rev;
      half_r  <= 8'd128 >> par_lvl_r;
    end
  end

  // current child: lowest octant still pending
  logic [2:0]    oct;
  logic [7:0]    rem_nxt;
  logic          full, push, do_push, ovf_now, last_c;
  coord_t        cx, cy, cz, half_c;
  logic [LW-1:0] lvl_c;
  logic [CW-1:0] cnt_after;
  status_t       child_st;

  always_comb begin
    oct = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem_r[i]) begin
        oct = 3'(i);
      end
    end
  end

  assign half_c    = coord_t'({16'd0, half_r});
  assign cx        = par_x_r + (oct[0] ? half_c : '0);
  assign cy        = par_y_r + (oct[1] ? half_c : '0);
  assign cz        = par_z_r + (oct[2] ? half_c : '0);
  assign lvl_c     = par_lvl_r + LW'(1);
  assign rem_nxt   = rem_r & ~(8'd1 << oct);
  assign last_c    = (rem_nxt == 8'd0);
  assign full      = (cnt_r == CW'(STACK_ENTRIES));
  assign push      = !leaf_r[oct];
  assign do_push   = push && !full;
  assign ovf_now   = ovf_r || (push && full);
  assign cnt_after = cnt_r + CW'(do_push);

  always_comb begin
    if (ovf_now) begin
      child_st = ST_OVERFLOW;
    end else if (last_c && cnt_after == '0) begin
      child_st = ST_DONE;
    end else begin
      child_st = ST_RUN;
    end
  end

  // mask, rank and overflow tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      rank_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.op == CMD_LATCH) begin
      rem_r  <= valid_rev;
      rank_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.op == CMD_CHILD && rem_r != 8'd0) begin
      rem_r  <= rem_nxt;
      rank_r <= rank_r + 3'd1;
      ovf_r  <= ovf_now;
    end
  end

  // stack write port and count
  always_comb begin
    stk_we    = 1'b0;
    stk_widx  = cnt_r[SW-1:0];
    stk_wdata = '{addr: first_r + AW'(rank_r), x: cx, y: cy, z: cz, lvl: lvl_c};
    cnt_nxt   = cnt_r;
    case (cmd.op)
      CMD_START: begin
        stk_we    = 1'b1;
        stk_widx  = '0;
        stk_wdata = '{addr: '0, x: root_x_r, y: root_y_r, z: root_z_r, lvl: '0};
        cnt_nxt   = CW'(1);
      end
      CMD_POP:  cnt_nxt = cnt_dec;
      CMD_FAIL: cnt_nxt = '0;
      CMD_CHILD: begin
        if (rem_r != 8'd0) begin
          stk_we  = do_push;
          cnt_nxt = (last_c && ovf_now) ? '0 : cnt_after;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  logic    out_vld_r;
  result_t out_r, res_nxt;
  logic    load;

  always_comb begin
    load    = 1'b1;
    res_nxt = '{box_valid: 1'b0, box_x: '0, box_y: '0, box_z: '0, box_level: '0,
                last: 1'b1, status: ST_DONE};
    case (cmd.op)
      CMD_START: begin
        res_nxt.box_valid = 1'b1;
        res_nxt.box_x     = root_x_r;
        res_nxt.box_y     = root_y_r;
        res_nxt.box_z     = root_z_r;
        res_nxt.status    = ST_RUN;
      end
      CMD_EMPTY: res_nxt.status = ST_DONE;
      CMD_FAIL:  res_nxt.status = cmd.code;
      CMD_CHILD: begin
        if (rem_r == 8'd0) begin
          res_nxt.status = (cnt_r == '0) ? ST_DONE : ST_RUN;
        end else begin
          res_nxt.box_valid = 1'b1;
          res_nxt.box_x     = cx;
          res_nxt.box_y     = cy;
          res_nxt.box_z     = cz;
          res_nxt.box_level = LEVEL_OUT_W'(lvl_c);
          res_nxt.last      = last_c;
          res_nxt.status    = child_st;
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;

  // status towards the controller
  assign sts.clear_done     = !clr_busy_r;
  assign sts.out_free       = !out_vld_r || out_tready;
  assign sts.stack_empty    = (cnt_r == '0);
  assign sts.level_bad      = (32'(stk_q.lvl) > 32'(max_depth_r)) ||
                              (32'(stk_q.lvl) >= 32'(LEVELS));
  assign sts.node_unwritten = !node_q[32];
  assign sts.last_child     = (rem_r == 8'd0) || last_c;

endmodule

>>> tb/octree_box_scoreboard_pkg.sv
// scoreboard for the octree child mask expander: node memory, traversal stack and box queue
// depends on ocme_pkg for the result struct, status codes and register indexes
package octree_box_scoreboard_pkg;
  import ocme_pkg::*;

  localparam int NODE_WORDS    = 4096;
  localparam int STACK_ENTRIES = 64;
  localparam int LEVELS        = 8;

  // operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class octree_box_scoreboard;
    logic [31:0] node_mem    [NODE_WORDS];
    bit          node_set    [NODE_WORDS];
    logic [11:0] stack_addr  [STACK_ENTRIES];
    coord_t      stack_x     [STACK_ENTRIES];
    coord_t      stack_y     [STACK_ENTRIES];
    coord_t      stack_z     [STACK_ENTRIES];
    int unsigned stack_level [STACK_ENTRIES];
    int unsigned stack_depth;
    int unsigned max_depth;
    coord_t      root_x, root_y, root_z;
    result_t     expected_boxes [$];
    int unsigned mismatches;

    function new();
      stack_depth = 0;
      max_depth   = MAX_DEPTH_RST;
      root_x      = ROOT_X_RST;
      root_y      = ROOT_Y_RST;
      root_z      = ROOT_Z_RST;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [COORD_W-1:0] value);
      case (index)
        REG_MAX_DEPTH: max_depth = value[2:0];
        REG_ROOT_X:    root_x = value;
        REG_ROOT_Y:    root_y = value;
        REG_ROOT_Z:    root_z = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_boxes.size();
    endfunction

    function bit traversal_live();
      return stack_depth != 0;
    endfunction

    // append one expected result at the tail of the queue
    function void add_expected(result_t r);
      expected_boxes = {expected_boxes, r};
    endfunction

    // single result without a box
    function void push_flag(status_t code);
      result_t r;
      r = '0;
      r.last   = 1'b1;
      r.status = code;
      add_expected(r);
    endfunction

    // work out the boxes caused by one accepted request
    function void note_request(logic [1:0] op, logic [11:0] addr, logic [31:0] word);
      result_t r;
      case (op)
        OP_WRITE: begin
          node_mem[addr] = word;
          node_set[addr] = 1'b1;
        end
        OP_START: begin
          stack_addr[0]  = '0;
          stack_x[0]     = root_x;
          stack_y[0]     = root_y;
          stack_z[0]     = root_z;
          stack_level[0] = 0;
          stack_depth    = 1;
          r = '0;
          r.box_valid = 1'b1;
          r.box_x     = root_x;
          r.box_y     = root_y;
          r.box_z     = root_z;
          r.last      = 1'b1;
          r.status    = ST_RUN;
          add_expected(r);
        end
        OP_EXPAND: expand_top();
        default: ;
      endcase
    endfunction

    // pop the newest entry and emit its valid children in octant order
    function void expand_top();
      logic [11:0] a, rank, child;
      coord_t      px, py, pz, cx, cy, cz, step;
      int unsigned lvl, n;
      logic [31:0] node;
      logic [7:0]  valid, leaf;
      bit          ovf;
      result_t     kids [8];
      if (stack_depth == 0) begin
        push_flag(ST_DONE);
        return;
      end
      stack_depth--;
      a   = stack_addr[stack_depth];
      px  = stack_x[stack_depth];
      py  = stack_y[stack_depth];
      pz  = stack_z[stack_depth];
      lvl = stack_level[stack_depth];
      if (lvl > max_depth || lvl >= LEVELS) begin
        stack_depth = 0;
        push_flag(ST_DONE);
        return;
      end
      if (!node_set[a]) begin
        stack_depth = 0;
        push_flag(ST_UNWRITTEN);
        return;
      end
      node  = node_mem[a];
      valid = node[15:8];
      leaf  = node[7:0];
      step  = coord_t'(256 >> (lvl + 1));
      rank  = '0;
      n     = 0;
      ovf   = 1'b0;
      for (int unsigned oct = 0; oct < 8; oct++) begin
        if (!valid[7 - oct]) continue;
        cx = oct[0] ? px + step : px;
        cy = oct[1] ? py + step : py;
        cz = oct[2] ? pz + step : pz;
        // inner child: address wraps with the node memory size
        if (!leaf[7 - oct]) begin
          child = node[27:16] + a + rank;
          if (stack_depth < STACK_ENTRIES) begin
            stack_addr[stack_depth]  = child;
            stack_x[stack_depth]     = cx;
            stack_y[stack_depth]     = cy;
            stack_z[stack_depth]     = cz;
            stack_level[stack_depth] = lvl + 1;
            stack_depth++;
          end else begin
            ovf = 1'b1;
          end
        end
        rank++;
        kids[n] = '0;
        kids[n].box_valid = 1'b1;
        kids[n].box_x     = cx;
        kids[n].box_y     = cy;
        kids[n].box_z     = cz;
        kids[n].box_level = 4'(lvl + 1);
        kids[n].status    = ovf ? ST_OVERFLOW : ST_RUN;
        n++;
      end
      if (ovf) stack_depth = 0;
      if (n == 0) begin
        push_flag(stack_depth == 0 ? ST_DONE : ST_RUN);
        return;
      end
      kids[n - 1].last = 1'b1;
      if (!ovf && stack_depth == 0) kids[n - 1].status = ST_DONE;
      for (int unsigned k = 0; k < n; k++) add_expected(kids[k]);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result with the oldest expected box
    function void check_box(result_t got);
      result_t want;
      if (expected_boxes.size() == 0) begin
        $error("result with nothing expected: box_valid %0d status %0d", got.box_valid,
               got.status);
        mismatches++;
        return;
      end
      want = expected_boxes.pop_front();
      compare("box_valid", want.box_valid, got.box_valid);
      compare("box_x", want.box_x, got.box_x);
      compare("box_y", want.box_y, got.box_y);
      compare("box_z", want.box_z, got.box_z);
      compare("box_level", want.box_level, got.box_level);
      compare("last", want.last, got.last);
      compare("status", want.status, got.status);
    endfunction
  endclass

endpackage

>>> tb/octree_child_mask_expander_top_test.sv
// testbench for octree_child_mask_expander_top: directed and random requests, random stalls
// depends on ocme_pkg, octree_box_scoreboard_pkg and the block's rtl
module octree_child_mask_expander_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ocme_pkg::*;
  import octree_box_scoreboard_pkg::*;

  localparam int     IDLE_LIMIT    = 20000;
  localparam int     SETTLE_CYCLES = 32;
  localparam int     LONG_HOLD     = 400;
  localparam int     PHASES        = 8;
  localparam int     PHASE_ITEMS   = 32;
  localparam coord_t COORD_MAX     = 24'h7FFFFF;
  localparam coord_t COORD_MIN     = 24'h800000;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_wen   = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [COORD_W-1:0]     cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [1:0]             in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  octree_box_scoreboard boxes = new();

  int unsigned burst_left       = 0;
  int unsigned counted_requests = 0;
  int unsigned hold_order       = 0;
  int unsigned hold_served      = 0;
  int unsigned hold_left        = 0;
  int unsigned mode_left        = 0;
  int unsigned idle_cycles      = 0;
  ready_mode_t ready_mode       = READY_ALWAYS;

  octree_child_mask_expander_top #(
    .NODE_WORDS   (NODE_WORDS),
    .STACK_ENTRIES(STACK_ENTRIES),
    .LEVELS       (LEVELS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure: pattern changes every so often, long hold when asked
  always @(posedge clk) begin
    if (hold_served != hold_order) begin
      hold_served = hold_order;
      hold_left   = LONG_HOLD;
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:      out_tready <= (mode_left % 3 == 0);
      endcase
    end
  end

  // unpack each accepted result and check it
  always @(posedge clk) begin : watch_results
    result_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.box_valid = out_tuser[0];
      got.status    = status_t'(out_tuser[2:1]);
      got.box_x     = out_tdata[23:0];
      got.box_y     = out_tdata[47:24];
      got.box_z     = out_tdata[71:48];
      got.box_level = out_tdata[75:72];
      got.last      = out_tlast;
      boxes.check_box(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("octree_child_mask_expander_top_test: done, errors");
      $finish;
    end
  end

  // offer one request, in bursts with random gaps, and note it once accepted
  task automatic send_request(input logic [1:0] op, input logic [11:0] addr,
                              input logic [31:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, word, addr};
    do @(posedge clk); while (in_tready !== 1'b1);
    boxes.note_request(op, addr, word);
    if (op != OP_UNUSED) counted_requests++;
  endtask

  // stop offering and wait for every expected box, then let the block settle
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (boxes.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers on consecutive cycles
  task automatic apply_settings(input logic [2:0] depth, input coord_t x, input coord_t y,
                                input coord_t z);
    logic [1:0]         index [4] = '{REG_MAX_DEPTH, REG_ROOT_X, REG_ROOT_Y, REG_ROOT_Z};
    logic [COORD_W-1:0] value [4];
    value = '{{21'd0, depth}, x, y, z};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= index[i];
      cfg_wdata <= value[i];
      @(posedge clk);
      boxes.set_register(index[i], value[i]);
    end
    cfg_wen <= 1'b0;
  endtask

  // node word with a mostly short pointer and few inner children
  function automatic logic [31:0] tree_word();
    logic [15:0] ptr;
    logic [7:0]  valid, inner, leaf;
    case ($urandom_range(0, 9))
      0:       ptr = 16'($urandom);
      1, 2:    ptr = 16'($urandom_range(0, 20));
      default: ptr = 16'($urandom_range(0, 3));
    endcase
    valid = 8'($urandom);
    inner = valid & 8'($urandom) & 8'($urandom);
    leaf  = (valid & ~inner) | (~valid & 8'($urandom));
    return {ptr, valid, leaf};
  endfunction

  // patch a few nodes near the root, start, then expand until the traversal ends or max_expands is reached
  task automatic run_traversal(input int unsigned max_expands);
    int unsigned expands;
    repeat ($urandom_range(0, 6)) send_request(OP_WRITE, 12'($urandom_range(0, 15)), tree_word());
    send_request(OP_START, 12'($urandom), $urandom);
    expands = 0;
    while (boxes.traversal_live() && expands < max_expands) begin
      send_request(OP_EXPAND, 12'($urandom), $urandom);
      expands++;
    end
    if ($urandom_range(0, 3) == 0) send_request(OP_EXPAND, 12'($urandom), $urandom);
  endtask

  initial begin
    int unsigned phase_end;
    logic [2:0]  depth;
    coord_t      corner [3];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, unwritten root, ignored operation
    send_request(OP_EXPAND, 12'd0, 32'd0);
    send_request(OP_START, 12'hFFF, 32'hFFFF_FFFF);
    send_request(OP_EXPAND, 12'd0, 32'd0);
    send_request(OP_UNUSED, 12'd0, 32'd0);
    // self loop through octant 0 until the level passes max_depth
    send_request(OP_WRITE, 12'd0, 32'h0000_8000);
    send_request(OP_START, 12'd0, 32'd0);
    repeat (8) send_request(OP_EXPAND, 12'd0, 32'd0);
    // pointer wraps to the top word, which has eight leaves
    send_request(OP_WRITE, 12'd0, 32'hFFFF_8000);
    send_request(OP_WRITE, 12'hFFF, 32'hFFFF_FFFF);
    send_request(OP_START, 12'd0, 32'd0);
    repeat (2) send_request(OP_EXPAND, 12'd0, 32'd0);
    // leaf bits set but no valid child
    send_request(OP_WRITE, 12'd0, 32'h0000_00FF);
    send_request(OP_START, 12'd0, 32'd0);
    send_request(OP_EXPAND, 12'd0, 32'd0);

    // random phases, each under its own settings
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0:       corner[c] = COORD_MIN;
          1:       corner[c] = COORD_MAX;
          default: corner[c] = coord_t'($urandom);
        endcase
      end
      depth = 3'($urandom_range(0, 7));
      if (phase == 0) begin
        depth  = 3'd7;
        corner = '{COORD_MAX, COORD_MAX, COORD_MAX};
      end else if (phase == 1) begin
        depth  = 3'd0;
        corner = '{COORD_MIN, COORD_MIN, COORD_MIN};
      end
      apply_settings(depth, corner[0], corner[1], corner[2]);
      // long receiver hold while requests keep coming
      if (phase == 3) hold_order++;
      phase_end = counted_requests + PHASE_ITEMS;
      while (counted_requests < phase_end) begin
        if ($urandom_range(0, 3) == 0)
          send_request(2'($urandom_range(0, 3)), 12'($urandom), $urandom);
        else
          run_traversal(24);
        if ($urandom_range(0, 15) == 0) drain_results();
      end
    end

    drain_results();
    if (boxes.mismatches == 0 && boxes.pending() == 0)
      $display("octree_child_mask_expander_top_test: done, clean");
    else
      $display("octree_child_mask_expander_top_test: done, errors");
    $finish;
  end

endmodule
